// ----- rtl/sdmt_pkg.sv -----
// ----------------------------------------------------------------------------
// sdmt_pkg: shared constants and types of the minimum-travel stroke block
// Widths of coordinates, distances and path costs, and the segment record.
// ----------------------------------------------------------------------------
package sdmt_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int COST_BITS  = 48;

    // Squared distance sum, and the radicand scaled by the fraction bits.
    localparam int SQ_BITS   = 2 * COORD_BITS;
    localparam int SUM_BITS  = SQ_BITS + 1;
    localparam int ROOT_BITS = (SUM_BITS + 2 * FRAC_BITS + 1) / 2;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS  = ROOT_BITS + 3;

    // Distance jobs per segment: its own length and four jumps.
    localparam int NJOBS    = 5;
    localparam int JOB_BITS = $clog2(NJOBS + 1);
    localparam int Q_DEPTH  = 4;
    localparam int Q_ABITS  = $clog2(Q_DEPTH);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [ROOT_BITS-1:0]         t_dist;
    typedef logic [COST_BITS-1:0]         t_cost;

    typedef struct packed {
        logic   start;
        t_coord c1x;
        t_coord c1y;
        t_coord c2x;
        t_coord c2y;
    } t_seg;

endpackage

// ----- rtl/sdmt_front.sv -----
// ----------------------------------------------------------------------------
// sdmt_front: input queue
// Takes segment beats, each with its path start or continuation flag, and holds
// them until the back end is free.
// ----------------------------------------------------------------------------
module sdmt_front import sdmt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_seg   i_seg,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_seg   o_seg
);

    t_seg               r_mem [Q_DEPTH];
    logic [Q_ABITS-1:0] r_wr;
    logic [Q_ABITS-1:0] r_rd;
    logic [Q_ABITS:0]   r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_cnt == (Q_ABITS+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_seg   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ----- rtl/sdmt_dist.sv -----
// ----------------------------------------------------------------------------
// sdmt_dist: pipelined Euclidean distance unit
// Absolute differences, squares, sum, then one root bit per stage.
// ----------------------------------------------------------------------------
module sdmt_dist import sdmt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_coord i_ax,
    input  t_coord i_ay,
    input  t_coord i_bx,
    input  t_coord i_by,
    output logic   o_valid,
    output t_dist  o_dist
);

    logic signed [COORD_BITS:0] w_dx;
    logic signed [COORD_BITS:0] w_dy;
    logic [COORD_BITS-1:0]      r_dx;
    logic [COORD_BITS-1:0]      r_dy;
    logic [SQ_BITS-1:0]         r_sqx;
    logic [SQ_BITS-1:0]         r_sqy;
    logic                       r_va;
    logic                       r_vb;

    logic                  r_v    [ROOT_BITS+1];
    logic [RAD_BITS-1:0]   r_rad  [ROOT_BITS+1];
    logic [REM_BITS-1:0]   r_rem  [ROOT_BITS+1];
    logic [ROOT_BITS-1:0]  r_root [ROOT_BITS+1];

    assign w_dx = $signed({i_ax[COORD_BITS-1], i_ax}) - $signed({i_bx[COORD_BITS-1], i_bx});
    assign w_dy = $signed({i_ay[COORD_BITS-1], i_ay}) - $signed({i_by[COORD_BITS-1], i_by});

    always_ff @(posedge i_clk) begin
        r_dx  <= COORD_BITS'(w_dx[COORD_BITS] ? -w_dx : w_dx);
        r_dy  <= COORD_BITS'(w_dy[COORD_BITS] ? -w_dy : w_dy);
        r_sqx <= r_dx * r_dx;
        r_sqy <= r_dy * r_dy;
        r_rad[0]  <= RAD_BITS'({1'b0, r_sqx} + {1'b0, r_sqy}) << (2 * FRAC_BITS);
        r_rem[0]  <= '0;
        r_root[0] <= '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va   <= 1'b0;
            r_vb   <= 1'b0;
            r_v[0] <= 1'b0;
        end else begin
            r_va   <= i_valid;
            r_vb   <= r_va;
            r_v[0] <= r_vb;
        end
    end

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
        logic [REM_BITS-1:0] w_rem;
        logic [REM_BITS-1:0] w_trial;

        assign w_rem   = {r_rem[k][REM_BITS-3:0], r_rad[k][RAD_BITS-1 -: 2]};
        assign w_trial = REM_BITS'({r_root[k], 2'b01});

        always_ff @(posedge i_clk) begin
            r_rad[k+1] <= r_rad[k] << 2;
            if (w_rem >= w_trial) begin
                r_rem[k+1]  <= w_rem - w_trial;
                r_root[k+1] <= {r_root[k][ROOT_BITS-2:0], 1'b1};
            end else begin
                r_rem[k+1]  <= w_rem;
                r_root[k+1] <= {r_root[k][ROOT_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    assign o_valid = r_v[ROOT_BITS];
    assign o_dist  = r_root[ROOT_BITS];

endmodule

// ----- rtl/sdmt_back.sv -----
// ----------------------------------------------------------------------------
// sdmt_back: path cost recurrence
// Issues the five distances of a segment, then extends both path costs (or
// restarts them at a path start) and presents the result in the output register.
// ----------------------------------------------------------------------------
module sdmt_back import sdmt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_q_empty,
    input  t_seg   i_q_seg,
    output logic   o_q_pop,
    output logic   o_d_valid,
    output t_coord o_d_ax,
    output t_coord o_d_ay,
    output t_coord o_d_bx,
    output t_coord o_d_by,
    input  logic   i_d_valid,
    input  t_dist  i_d_dist,
    input  logic   i_pop,
    output logic   o_empty,
    output t_cost  o_best_total,
    output logic   o_ends_at_second,
    output logic   o_saturated
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ISSUE = 6'b000010,
        S_WAIT  = 6'b000100,
        S_SUM   = 6'b001000,
        S_MIN   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    localparam logic [JOB_BITS-1:0] JOB_LEN  = JOB_BITS'(0);
    localparam logic [JOB_BITS-1:0] JOB_P1C1 = JOB_BITS'(1);
    localparam logic [JOB_BITS-1:0] JOB_P2C1 = JOB_BITS'(2);
    localparam logic [JOB_BITS-1:0] JOB_P2C2 = JOB_BITS'(3);
    localparam logic [JOB_BITS-1:0] JOB_P1C2 = JOB_BITS'(4);
    localparam logic [JOB_BITS-1:0] JOB_LAST = JOB_BITS'(NJOBS - 1);
    localparam logic [JOB_BITS-1:0] JOB_ALL  = JOB_BITS'(NJOBS);
    localparam t_cost COST_MAX = '1;

    t_state              r_state;
    t_state              n_state;
    t_seg                r_item;
    logic [JOB_BITS-1:0] r_job;
    logic [JOB_BITS-1:0] r_got;
    t_dist               r_dist [NJOBS];
    t_coord              r_p1x, r_p1y, r_p2x, r_p2y;
    t_cost               r_cf, r_cs;
    logic                r_psat;
    t_cost               r_a, r_b, r_c, r_d;
    logic                r_sum_sat;
    t_cost               r_nf, r_ns;
    logic                r_step_sat;
    logic                r_out_v;
    t_cost               r_best;
    logic                r_at2;
    logic                r_osat;

    logic [COST_BITS:0]  w_a, w_b, w_c, w_d, w_ns, w_nf;
    t_cost               w_len, w_minab, w_mincd;
    logic                w_commit;

    assign w_len    = COST_BITS'(r_dist[0]);
    assign w_a      = {1'b0, COST_BITS'(r_dist[1])} + {1'b0, r_cf};
    assign w_b      = {1'b0, COST_BITS'(r_dist[2])} + {1'b0, r_cs};
    assign w_c      = {1'b0, COST_BITS'(r_dist[3])} + {1'b0, r_cs};
    assign w_d      = {1'b0, COST_BITS'(r_dist[4])} + {1'b0, r_cf};
    assign w_minab  = (r_a < r_b) ? r_a : r_b;
    assign w_mincd  = (r_c < r_d) ? r_c : r_d;
    assign w_ns     = {1'b0, w_len} + {1'b0, w_minab};
    assign w_nf     = {1'b0, w_len} + {1'b0, w_mincd};
    assign w_commit = r_state[5] && (!r_out_v || i_pop);

    assign o_q_pop   = (r_state == S_IDLE) && !i_q_empty;
    assign o_d_valid = (r_state == S_ISSUE);

    always_comb begin
        o_d_ax = r_item.c1x;
        o_d_ay = r_item.c1y;
        o_d_bx = r_item.c2x;
        o_d_by = r_item.c2y;
        unique case (r_job)
            JOB_LEN: begin
            end
            JOB_P1C1: begin
                o_d_ax = r_p1x;
                o_d_ay = r_p1y;
                o_d_bx = r_item.c1x;
                o_d_by = r_item.c1y;
            end
            JOB_P2C1: begin
                o_d_ax = r_p2x;
                o_d_ay = r_p2y;
                o_d_bx = r_item.c1x;
                o_d_by = r_item.c1y;
            end
            JOB_P2C2: begin
                o_d_ax = r_p2x;
                o_d_ay = r_p2y;
            end
            JOB_P1C2: begin
                o_d_ax = r_p1x;
                o_d_ay = r_p1y;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (!i_q_empty) n_state = S_ISSUE;
            S_ISSUE: if (r_job == JOB_LAST) n_state = S_WAIT;
            S_WAIT:  if (r_got == JOB_ALL) n_state = S_SUM;
            S_SUM:   n_state = S_MIN;
            S_MIN:   n_state = S_OUT;
            S_OUT:   if (w_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Payload registers of the recurrence.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_seg;
        end
        if (i_d_valid) begin
            r_dist[r_got[$clog2(NJOBS)-1:0]] <= i_d_dist;
        end
        if (r_state == S_SUM) begin
            r_a <= w_a[COST_BITS] ? COST_MAX : w_a[COST_BITS-1:0];
            r_b <= w_b[COST_BITS] ? COST_MAX : w_b[COST_BITS-1:0];
            r_c <= w_c[COST_BITS] ? COST_MAX : w_c[COST_BITS-1:0];
            r_d <= w_d[COST_BITS] ? COST_MAX : w_d[COST_BITS-1:0];
            r_sum_sat <= w_a[COST_BITS] | w_b[COST_BITS] | w_c[COST_BITS] | w_d[COST_BITS];
        end
        if (r_state == S_MIN) begin
            if (r_item.start) begin
                r_ns       <= w_len;
                r_nf       <= w_len;
                r_step_sat <= 1'b0;
            end else begin
                r_ns       <= w_ns[COST_BITS] ? COST_MAX : w_ns[COST_BITS-1:0];
                r_nf       <= w_nf[COST_BITS] ? COST_MAX : w_nf[COST_BITS-1:0];
                r_step_sat <= r_sum_sat | w_ns[COST_BITS] | w_nf[COST_BITS];
            end
        end
        if (w_commit) begin
            r_best <= (r_ns < r_nf) ? r_ns : r_nf;
            r_at2  <= (r_ns < r_nf);
            r_osat <= r_step_sat | (r_psat & !r_item.start);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= '0;
            r_got   <= '0;
            r_out_v <= 1'b0;
            r_p1x   <= '0;
            r_p1y   <= '0;
            r_p2x   <= '0;
            r_p2y   <= '0;
            r_cf    <= '0;
            r_cs    <= '0;
            r_psat  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                r_job <= '0;
                r_got <= '0;
            end else begin
                if (r_state == S_ISSUE) r_job <= r_job + 1'b1;
                if (i_d_valid)          r_got <= r_got + 1'b1;
            end
            if (w_commit) begin
                r_out_v <= 1'b1;
                r_p1x   <= r_item.c1x;
                r_p1y   <= r_item.c1y;
                r_p2x   <= r_item.c2x;
                r_p2y   <= r_item.c2y;
                r_cf    <= r_nf;
                r_cs    <= r_ns;
                r_psat  <= r_step_sat | (r_psat & !r_item.start);
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_empty          = !r_out_v;
    assign o_best_total     = r_best;
    assign o_ends_at_second = r_at2;
    assign o_saturated      = r_osat;

endmodule

// ----- rtl/stroke_direction_min_travel_core.sv -----
// ----------------------------------------------------------------------------
// stroke_direction_min_travel_core: minimum-travel stroke direction
// Chooses the drawing direction of each segment so that the path is shortest.
// ----------------------------------------------------------------------------
// Segments enter through a queue interface: a beat is taken when push is high
// and full is low. A start flag opens a new path; otherwise the segment
// continues the current one. Up to four segments wait in the input queue.
// Results leave the same way: while empty is low the oldest result stands on
// the output ports, and it is taken when pop is high.
// Each segment needs five distances, issued one per cycle into a pipelined
// square-root unit of 28 stages. The back end then waits for the last distance
// to arrive, and its sum, min and output states add, clamp and compare. One
// segment is processed at a time, so a new segment leaves the front of the
// queue only once the result of the previous one has been committed.
// If the receiver stalls, the finished result is held and the next segment is
// carried up to its final commit, while further beats collect in the queue.
// Synchronous reset empties both queues, puts the previous endpoints at the
// origin and clears both path costs and the saturation flag.
// ----------------------------------------------------------------------------
module stroke_direction_min_travel_core import sdmt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   push,
    output logic   full,
    input  logic   i_start_new_path,
    input  t_coord i_first_end_x,
    input  t_coord i_first_end_y,
    input  t_coord i_second_end_x,
    input  t_coord i_second_end_y,
    output logic   empty,
    input  logic   pop,
    output t_cost  o_best_total,
    output logic   o_ends_at_second,
    output logic   o_saturated
);

    t_seg   w_in_seg;
    t_seg   w_q_seg;
    logic   w_q_empty;
    logic   w_q_pop;
    logic   w_d_valid;
    t_coord w_ax, w_ay, w_bx, w_by;
    logic   w_r_valid;
    t_dist  w_r_dist;

    assign w_in_seg = '{start: i_start_new_path, c1x: i_first_end_x, c1y: i_first_end_y,
                        c2x: i_second_end_x, c2y: i_second_end_y};

    sdmt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_seg   (w_in_seg),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_seg   (w_q_seg)
    );

    sdmt_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d_valid),
        .i_ax    (w_ax),
        .i_ay    (w_ay),
        .i_bx    (w_bx),
        .i_by    (w_by),
        .o_valid (w_r_valid),
        .o_dist  (w_r_dist)
    );

    sdmt_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (w_q_empty),
        .i_q_seg          (w_q_seg),
        .o_q_pop          (w_q_pop),
        .o_d_valid        (w_d_valid),
        .o_d_ax           (w_ax),
        .o_d_ay           (w_ay),
        .o_d_bx           (w_bx),
        .o_d_by           (w_by),
        .i_d_valid        (w_r_valid),
        .i_d_dist         (w_r_dist),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_best_total     (o_best_total),
        .o_ends_at_second (o_ends_at_second),
        .o_saturated      (o_saturated)
    );

endmodule

// ----- tb/sv/stroke_direction_min_travel_checker.sv -----
// ----------------------------------------------------------------------------
// stroke_direction_min_travel_checker: result predictor and comparator
// Watches the segment and result queues of the core and computes each best
// path cost, finishing end and saturation flag. Every result beat is checked
// against the oldest prediction.
// ----------------------------------------------------------------------------
module stroke_direction_min_travel_checker import sdmt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  logic   i_full,
    input  logic   i_start_new_path,
    input  t_coord i_first_end_x,
    input  t_coord i_first_end_y,
    input  t_coord i_second_end_x,
    input  t_coord i_second_end_y,
    input  logic   i_empty,
    input  logic   i_pop,
    input  t_cost  i_best_total,
    input  logic   i_ends_at_second,
    input  logic   i_saturated,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_results_seen,
    output int     o_saturated_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] COST_TOP = (64'd1 << COST_BITS) - 64'd1;

    typedef struct {
        t_cost total;
        logic  at_second;
        logic  sat;
    } t_outcome;

    t_outcome    outcome_q[$];
    t_coord      last_ax, last_ay, last_bx, last_by;
    logic [63:0] cost_to_first, cost_to_second;
    logic        path_clamped;
    logic        clamp_hit;

    assign o_pending = outcome_q.size();

    function automatic logic [63:0] clamp_cost(input logic [64:0] v);
        if (v > {1'b0, COST_TOP}) begin
            clamp_hit = 1'b1;
            return COST_TOP;
        end
        return v[63:0];
    endfunction

    // Bit-serial root of (dx^2 + dy^2) << 2*FRAC_BITS, rounded down.
    function automatic logic [63:0] seg_span(input t_coord ax, input t_coord ay,
                                             input t_coord bx, input t_coord by);
        logic signed [32:0] dx, dy;
        logic [127:0] rad, rem, root, bitv;
        dx = ax - bx;
        dy = ay - by;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        rad = (128'(dx) * 128'(dx) + 128'(dy) * 128'(dy)) << (2 * FRAC_BITS);
        rem = rad;
        root = 0;
        bitv = 128'd1 << 126;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return clamp_cost({1'b0, root[63:0]});
    endfunction

    function automatic logic [63:0] umin64(input logic [63:0] a, input logic [63:0] b);
        return (a < b) ? a : b;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    task automatic predict_segment();
        logic [63:0] span, a, b, c, d, nf, ns;
        t_outcome o;
        clamp_hit = 1'b0;
        span = seg_span(i_first_end_x, i_first_end_y, i_second_end_x, i_second_end_y);
        if (i_start_new_path) begin
            nf = span;
            ns = span;
            path_clamped = 1'b0;
        end else begin
            a = clamp_cost(65'(seg_span(last_ax, last_ay, i_first_end_x, i_first_end_y))
                           + 65'(cost_to_first));
            b = clamp_cost(65'(seg_span(last_bx, last_by, i_first_end_x, i_first_end_y))
                           + 65'(cost_to_second));
            c = clamp_cost(65'(seg_span(last_bx, last_by, i_second_end_x, i_second_end_y))
                           + 65'(cost_to_second));
            d = clamp_cost(65'(seg_span(last_ax, last_ay, i_second_end_x, i_second_end_y))
                           + 65'(cost_to_first));
            ns = clamp_cost(65'(span) + 65'(umin64(a, b)));
            nf = clamp_cost(65'(span) + 65'(umin64(c, d)));
        end
        if (clamp_hit) path_clamped = 1'b1;
        cost_to_first = nf;
        cost_to_second = ns;
        last_ax = i_first_end_x;
        last_ay = i_first_end_y;
        last_bx = i_second_end_x;
        last_by = i_second_end_y;
        o.total = t_cost'(umin64(nf, ns));
        o.at_second = (ns < nf);
        o.sat = path_clamped;
        outcome_q.push_back(o);
    endtask

    initial begin
        o_fail_count = 0;
        o_results_seen = 0;
        o_saturated_seen = 0;
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            last_ax = '0;
            last_ay = '0;
            last_bx = '0;
            last_by = '0;
            cost_to_first = '0;
            cost_to_second = '0;
            path_clamped = 1'b0;
            outcome_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected",
                                    64'(i_best_total), 64'd0);
                end else begin
                    want = outcome_q.pop_front();
                    o_results_seen++;
                    if (want.sat) o_saturated_seen++;
                    if (i_best_total !== want.total)
                        report_mismatch("best_total", 64'(i_best_total), 64'(want.total));
                    if (i_ends_at_second !== want.at_second)
                        report_mismatch("ends_at_second", 64'(i_ends_at_second),
                                        64'(want.at_second));
                    if (i_saturated !== want.sat)
                        report_mismatch("saturated", 64'(i_saturated), 64'(want.sat));
                end
            end
            if (i_push && !i_full) predict_segment();
        end
    end

endmodule

// ----- tb/sv/tb_stroke_direction_min_travel_core.sv -----
// ----------------------------------------------------------------------------
// tb_stroke_direction_min_travel_core: testbench of the stroke direction core
// Drives directed and random segment streams under varied sender and receiver
// idling, and takes the verdict from the checker beside the core.
// ----------------------------------------------------------------------------
module tb_stroke_direction_min_travel_core;
    import sdmt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_SEGMENTS = 1300;
    localparam int CYCLE_LIMIT     = 900000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   push = 1'b0;
    logic   pop = 1'b0;
    logic   full, empty;
    logic   i_start_new_path = 1'b0;
    t_coord i_first_end_x = '0, i_first_end_y = '0;
    t_coord i_second_end_x = '0, i_second_end_y = '0;
    t_cost  o_best_total;
    logic   o_ends_at_second, o_saturated;

    int fail_count, pending, results_seen, saturated_seen;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int cycle_count = 0;
    int segments_sent = 0;

    always #5 i_clk = ~i_clk;

    stroke_direction_min_travel_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_start_new_path(i_start_new_path),
        .i_first_end_x   (i_first_end_x),
        .i_first_end_y   (i_first_end_y),
        .i_second_end_x  (i_second_end_x),
        .i_second_end_y  (i_second_end_y),
        .empty           (empty),
        .pop             (pop),
        .o_best_total    (o_best_total),
        .o_ends_at_second(o_ends_at_second),
        .o_saturated     (o_saturated)
    );

    stroke_direction_min_travel_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_start_new_path(i_start_new_path),
        .i_first_end_x   (i_first_end_x),
        .i_first_end_y   (i_first_end_y),
        .i_second_end_x  (i_second_end_x),
        .i_second_end_y  (i_second_end_y),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_best_total    (o_best_total),
        .i_ends_at_second(o_ends_at_second),
        .i_saturated     (o_saturated),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_results_seen  (results_seen),
        .o_saturated_seen(saturated_seen)
    );

    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= receiver_stall_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("run stopped at the cycle limit");
            $display("simulation failed");
            $finish;
        end
    end

    // Mostly small coordinates so that jumps stay comparable, with some full range.
    function automatic t_coord pick_coord();
        case ($urandom_range(9))
            0:       return t_coord'($urandom);
            1:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return t_coord'($signed($urandom_range(400)) - 200);
        endcase
    endfunction

    // Presents one segment beat and holds it until the core takes it.
    task automatic send_segment(input logic start, input t_coord ax, input t_coord ay,
                                input t_coord bx, input t_coord by);
        while ($urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_start_new_path <= start;
        i_first_end_x <= ax;
        i_first_end_y <= ay;
        i_second_end_x <= bx;
        i_second_end_y <= by;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        segments_sent++;
    endtask

    task automatic go_quiet();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int phase_pct[4][2] = '{'{0, 0}, '{61, 0}, '{0, 61}, '{7, 7}};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No start after reset: continue from the origin.
        send_segment(1'b0, 16'sd3, 16'sd4, 16'sd6, 16'sd8);
        send_segment(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_segment(1'b1, 16'sd10, 16'sd0, 16'sd10, 16'sd0);
        // Tie between both ends: a symmetric segment.
        send_segment(1'b0, 16'sd0, 16'sd5, 16'sd0, -16'sd5);
        send_segment(1'b0, 16'sd1, 16'sd1, -16'sd1, -16'sd1);
        // Extreme coordinates and the longest possible lengths.
        send_segment(1'b1, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_segment(1'b0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        send_segment(1'b0, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        send_segment(1'b0, -16'sd1, -16'sd1, 16'sh7fff, 16'sh8000);
        send_segment(1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_segment(1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        // Reversed segment that should flip the drawing direction.
        send_segment(1'b1, 16'sd0, 16'sd0, 16'sd100, 16'sd0);
        send_segment(1'b0, 16'sd200, 16'sd0, 16'sd100, 16'sd1);
        send_segment(1'b0, 16'sd5, 16'sd5, -16'sd5, -16'sd5);
        go_quiet();

        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = phase_pct[ph][0];
            receiver_stall_pct = phase_pct[ph][1];
            for (int k = 0; k < RANDOM_SEGMENTS / 4; k++)
                send_segment($urandom_range(11) == 0, pick_coord(), pick_coord(),
                             pick_coord(), pick_coord());
            // Let everything drain before the next idling pattern.
            go_quiet();
        end
        sender_idle_pct = 0;
        receiver_stall_pct = 0;

        push <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("%0d segments sent, %0d results checked, %0d with the path saturated",
                 segments_sent, results_seen, saturated_seen);
        $display("idling phases: none, sender, receiver, both");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
